### sv/mrfd_pkg.sv
// Shared types and constants for the Manchester remote frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package mrfd_pkg;

   // Widths of the configuration fields
   localparam int SHORT_BITS  = 16;
   localparam int GAP_BITS    = 20;
   localparam int LEN_BITS    = 7;
   localparam int COUNT_BITS  = 8;
   localparam int CODE_BITS   = 64;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 20;
   localparam int QUEUE_DEPTH = 2;

   // Register reset values
   localparam logic [SHORT_BITS-1:0] HALF_BIT_RESET    = 16'd1000;
   localparam logic [SHORT_BITS-1:0] FULL_BIT_RESET    = 16'd2000;
   localparam logic [SHORT_BITS-1:0] PULSE_TOL_RESET   = 16'd350;
   localparam logic [GAP_BITS-1:0]   HDR_GAP_RESET     = 20'd10000;
   localparam logic [GAP_BITS-1:0]   HDR_TOL_RESET     = 20'd2800;
   localparam logic [GAP_BITS-1:0]   RESYNC_RESET      = 20'd4200;
   localparam logic [LEN_BITS-1:0]   FRAME_LEN_RESET   = 7'd49;

   // Register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_HALF_BIT_TIME    = 3'd0,
      REG_FULL_BIT_TIME    = 3'd1,
      REG_PULSE_TOLERANCE  = 3'd2,
      REG_HEADER_GAP_TIME  = 3'd3,
      REG_HEADER_TOLERANCE = 3'd4,
      REG_RESYNC_GAP_LIMIT = 3'd5,
      REG_FRAME_LENGTH     = 3'd6
   } csr_index_type;

   // Manchester decoder phase
   typedef enum logic [1:0] {
      PHASE_RESET     = 2'd0,
      PHASE_WAIT      = 2'd1,
      PHASE_HALF_LOW  = 2'd2,
      PHASE_HALF_HIGH = 2'd3
   } phase_type;

   // Configuration registers
   typedef struct packed {
      logic [SHORT_BITS-1:0] half_bit_time;
      logic [SHORT_BITS-1:0] full_bit_time;
      logic [SHORT_BITS-1:0] pulse_tolerance;
      logic [GAP_BITS-1:0]   header_gap_time;
      logic [GAP_BITS-1:0]   header_tolerance;
      logic [GAP_BITS-1:0]   resync_gap_limit;
      logic [LEN_BITS-1:0]   frame_length;
   } cfg_type;

   // Classified pulse passed from front to back
   typedef struct packed {
      logic high;
      logic hdr_ok;
      logic is_short;
      logic is_long;
      logic is_gap;
   } class_type;

endpackage

`default_nettype wire

### sv/mrfd_front.sv
// Front end: classifies each pulse item against the configured limits.
`timescale 1ns / 1ps
`default_nettype none

module mrfd_front
   import mrfd_pkg::*;
#(
   parameter int DURATION_BITS = 20
) (
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_line_level,
   input  wire logic [DURATION_BITS-1:0] req_pulse_duration,
   input  wire cfg_type                  cfg,
   input  wire logic                     q_full,
   output logic                          push,
   output class_type                     push_cls
);

   localparam int CW = (DURATION_BITS > GAP_BITS) ? DURATION_BITS : GAP_BITS;

   logic [CW-1:0] dur;
   logic [CW-1:0] half_t;
   logic [CW-1:0] full_t;
   logic [CW-1:0] hdr_t;
   logic [CW-1:0] dist_half;
   logic [CW-1:0] dist_full;
   logic [CW-1:0] dist_hdr;
   logic          near_half;
   logic          near_full;

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   assign dur    = CW'(req_pulse_duration);
   assign half_t = CW'(cfg.half_bit_time);
   assign full_t = CW'(cfg.full_bit_time);
   assign hdr_t  = CW'(cfg.header_gap_time);

   // Absolute distances to the nominal durations
   always_comb begin
      dist_half = (dur >= half_t) ? dur - half_t : half_t - dur;
      dist_full = (dur >= full_t) ? dur - full_t : full_t - dur;
      dist_hdr  = (dur >= hdr_t)  ? dur - hdr_t  : hdr_t - dur;
   end

   assign near_half = dist_half < CW'(cfg.pulse_tolerance);
   assign near_full = dist_full < CW'(cfg.pulse_tolerance);

   // Short wins over long
   always_comb begin
      push_cls.high     = req_line_level;
      push_cls.hdr_ok   = !req_line_level && (dist_hdr < CW'(cfg.header_tolerance));
      push_cls.is_short = near_half;
      push_cls.is_long  = !near_half && near_full;
      push_cls.is_gap   = !req_line_level && (dur > CW'(cfg.resync_gap_limit));
   end

endmodule

`default_nettype wire

### sv/mrfd_queue.sv
// Short queue of classified items between front and back.
`timescale 1ns / 1ps
`default_nettype none

module mrfd_queue
   import mrfd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire class_type push_cls,
   output logic           full,
   input  wire logic      pop,
   output logic           q_valid,
   output class_type      q_cls
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   class_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full    = count_ff == CNT_BITS'(QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_cls   = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cls;
      end
   end

endmodule

`default_nettype wire

### sv/mrfd_back.sv
// Back end: frame tracking, Manchester decoding and result register.
`timescale 1ns / 1ps
`default_nettype none

module mrfd_back
   import mrfd_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  wire class_type            q_cls,
   output logic                      pop,
   input  wire logic [LEN_BITS-1:0]  frame_length,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [WORD_BITS-1:0]      rsp_word,
   output logic                      rsp_ended_by_gap
);

   logic                  rx_ff, rx_in;
   phase_type             phase_ff, phase_in;
   logic [WORD_BITS-1:0]  word_ff, word_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  out_valid_ff;
   logic [WORD_BITS-1:0]  out_word_ff;
   logic                  out_gap_ff;
   logic                  emit;
   logic                  emit_gap;
   logic [WORD_BITS-1:0]  emit_word;
   logic                  bit_ready;
   logic                  bit_val;
   logic [COUNT_BITS-1:0] len_ext;

   assign len_ext = {1'b0, frame_length};
   assign pop     = q_valid && (!out_valid_ff || rsp_ready);

   // Frame state and phase next-state logic
   always_comb begin
      rx_in     = rx_ff;
      phase_in  = phase_ff;
      word_in   = word_ff;
      cnt_in    = cnt_ff;
      emit      = 1'b0;
      emit_gap  = 1'b0;
      emit_word = word_ff;
      bit_ready = 1'b0;
      bit_val   = 1'b0;
      if (pop) begin
         if (!rx_ff) begin
            // waiting for header gap
            if (q_cls.hdr_ok) begin
               rx_in    = 1'b1;
               word_in  = WORD_BITS'(1);
               cnt_in   = COUNT_BITS'(1);
               phase_in = PHASE_RESET;
            end
         end else if (q_cls.is_short || q_cls.is_long) begin
            case (phase_ff)
               PHASE_HALF_LOW: begin
                  if (q_cls.high && q_cls.is_short) begin
                     bit_ready = 1'b1;
                     bit_val   = 1'b0;
                  end
                  phase_in = PHASE_WAIT;
               end
               PHASE_HALF_HIGH: begin
                  if (!q_cls.high && q_cls.is_short) begin
                     bit_ready = 1'b1;
                     bit_val   = 1'b1;
                  end
                  phase_in = PHASE_WAIT;
               end
               default: begin
                  phase_in = PHASE_WAIT;
                  if (q_cls.is_short) begin
                     phase_in = q_cls.high ? PHASE_HALF_HIGH : PHASE_HALF_LOW;
                  end else begin
                     bit_ready = 1'b1;
                     bit_val   = q_cls.high;
                  end
               end
            endcase
            if (bit_ready) begin
               word_in   = {word_ff[WORD_BITS-2:0], bit_val};
               cnt_in    = cnt_ff + 1'b1;
               emit_word = word_in;
               emit      = cnt_in == len_ext;
            end
         end else if (q_cls.is_gap) begin
            // resync gap: flush a complete frame, then restart
            if (cnt_ff == len_ext) begin
               emit     = 1'b1;
               emit_gap = 1'b1;
            end
            word_in  = WORD_BITS'(1);
            cnt_in   = COUNT_BITS'(1);
            phase_in = PHASE_RESET;
         end else begin
            rx_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_ff    <= 1'b0;
         phase_ff <= PHASE_RESET;
         word_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         rx_ff    <= rx_in;
         phase_ff <= phase_in;
         word_ff  <= word_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_word_ff <= emit_word;
         out_gap_ff  <= emit_gap;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_word         = out_word_ff;
   assign rsp_ended_by_gap = out_gap_ff;

   // Header starts a fresh frame
   a_header_start: assert property (@(posedge clock) disable iff (reset)
      pop && !rx_ff && q_cls.hdr_ok |=>
         rx_ff && cnt_ff == COUNT_BITS'(1) && word_ff == WORD_BITS'(1))
      else $error("header did not start a frame");

   // A new result only comes from a popped item
   a_emit_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(pop))
      else $error("result appeared without a popped item");

   // A gap restarts the frame
   a_gap_restart: assert property (@(posedge clock) disable iff (reset)
      pop && rx_ff && !q_cls.is_short && !q_cls.is_long && q_cls.is_gap |=>
         cnt_ff == COUNT_BITS'(1) && phase_ff == PHASE_RESET && rx_ff)
      else $error("gap did not restart the frame");

endmodule

`default_nettype wire

### sv/manchester_remote_frame_decoder_unit.sv
// Top level of the Manchester remote frame decoder: registers and wiring.
`timescale 1ns / 1ps
`default_nettype none

// Decodes pulse items (level plus duration in microseconds) from a remote into
// Manchester frames. One item is accepted every cycle unless the queue is full:
// the front end compares the duration against the configured limits in the
// accept cycle and writes the class into a two-entry queue; the back end takes
// one queued item per cycle unless a result waits untaken, updates the frame
// word and bit count, and loads the result register. A frame reaches the rsp_
// channel via the queue and the result register; the queue keeps taking items
// while a result waits, until full. Configuration writes are taken every cycle
// (csr_ready is always high) and must be made while the block is idle.
module manchester_remote_frame_decoder_unit
   import mrfd_pkg::*;
#(
   parameter int WORD_BITS     = 64,
   parameter int DURATION_BITS = 20
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_line_level,
   input  wire logic [DURATION_BITS-1:0]  req_pulse_duration,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [CODE_BITS-1:0]           rsp_frame_code,
   output logic                           rsp_ended_by_gap,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   cfg_type              cfg_ff;
   logic                 push;
   class_type            push_cls;
   logic                 q_full;
   logic                 q_valid;
   class_type            q_cls;
   logic                 pop;
   logic [WORD_BITS-1:0] rsp_word;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_bit_time    <= HALF_BIT_RESET;
         cfg_ff.full_bit_time    <= FULL_BIT_RESET;
         cfg_ff.pulse_tolerance  <= PULSE_TOL_RESET;
         cfg_ff.header_gap_time  <= HDR_GAP_RESET;
         cfg_ff.header_tolerance <= HDR_TOL_RESET;
         cfg_ff.resync_gap_limit <= RESYNC_RESET;
         cfg_ff.frame_length     <= FRAME_LEN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_HALF_BIT_TIME:    cfg_ff.half_bit_time    <= csr_data[SHORT_BITS-1:0];
            REG_FULL_BIT_TIME:    cfg_ff.full_bit_time    <= csr_data[SHORT_BITS-1:0];
            REG_PULSE_TOLERANCE:  cfg_ff.pulse_tolerance  <= csr_data[SHORT_BITS-1:0];
            REG_HEADER_GAP_TIME:  cfg_ff.header_gap_time  <= csr_data[GAP_BITS-1:0];
            REG_HEADER_TOLERANCE: cfg_ff.header_tolerance <= csr_data[GAP_BITS-1:0];
            REG_RESYNC_GAP_LIMIT: cfg_ff.resync_gap_limit <= csr_data[GAP_BITS-1:0];
            REG_FRAME_LENGTH:     cfg_ff.frame_length     <= csr_data[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   mrfd_front #(
      .DURATION_BITS (DURATION_BITS)
   ) u_front (
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_line_level     (req_line_level),
      .req_pulse_duration (req_pulse_duration),
      .cfg                (cfg_ff),
      .q_full             (q_full),
      .push               (push),
      .push_cls           (push_cls)
   );

   mrfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cls (push_cls),
      .full     (q_full),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_cls    (q_cls)
   );

   mrfd_back #(
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_cls            (q_cls),
      .pop              (pop),
      .frame_length     (cfg_ff.frame_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .rsp_ended_by_gap (rsp_ended_by_gap)
   );

   // Bits above the word width read as zero
   assign rsp_frame_code = CODE_BITS'(rsp_word);

endmodule

`default_nettype wire
